/* design/ggpw_pkg.sv */
// Package for the grid greedy path walker: field widths, codes, FSM states
// and the neighbour offset tables. No dependencies.

package ggpw_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 3;
  localparam int CNT_W      = 12;
  localparam int CFG_W      = 7;
  localparam int EPOCH_W    = 8;
  localparam int FIELD_SPAN = 64;
  localparam int NB_COUNT   = 8;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int ROWS_RESET   = 50;
  localparam int COLS_RESET   = 35;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 12'd4095;
  localparam logic [KIND_W-1:0] CELL_FREE = 2'd0;
  localparam logic [KIND_W-1:0] CELL_OBST = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_BEGIN = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_ARRIVED   = 3'd1,
    STAT_START_BLK = 3'd2,
    STAT_DEST_BLK  = 3'd3,
    STAT_STUCK     = 3'd4,
    STAT_IDLE      = 3'd5
  } status_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_BRD_S,
    S_BRD_D,
    S_BCHK,
    S_BMARK,
    S_STEP,
    S_MOVE,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    OFF_DEC,
    OFF_ZERO,
    OFF_INC
  } off_e;

  // Neighbour order: up, up-left, up-right, down, down-left, down-right, left, right.
  function automatic off_e nb_dr(logic [2:0] k);
    off_e o;
    unique case (k)
      3'd0, 3'd1, 3'd2: o = OFF_DEC;
      3'd3, 3'd4, 3'd5: o = OFF_INC;
      default:          o = OFF_ZERO;
    endcase
    return o;
  endfunction

  function automatic off_e nb_dc(logic [2:0] k);
    off_e o;
    unique case (k)
      3'd1, 3'd4, 3'd6: o = OFF_DEC;
      3'd2, 3'd5, 3'd7: o = OFF_INC;
      default:          o = OFF_ZERO;
    endcase
    return o;
  endfunction

  // Moving below zero wraps to 127, which lies outside every bound.
  function automatic logic [CFG_W-1:0] apply_off(logic [ROW_W-1:0] p, off_e o);
    logic [CFG_W-1:0] v;
    v = {1'b0, p};
    unique case (o)
      OFF_DEC:  v = v - 7'd1;
      OFF_INC:  v = v + 7'd1;
      default:  v = v;
    endcase
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] abs_diff(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* design/ggpw_ifs.sv */
// Channel interfaces of the grid greedy path walker: command items in,
// walker results out. Depends on ggpw_pkg for the field widths.

interface ggpw_in_if import ggpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [KIND_W-1:0] cell_kind;
  logic [ROW_W-1:0]  dest_row;
  logic [COL_W-1:0]  dest_col;

  modport source (output valid, op, row, col, cell_kind, dest_row, dest_col,
                  input ready);
  modport sink (input valid, op, row, col, cell_kind, dest_row, dest_col,
                output ready);
endinterface

interface ggpw_out_if import ggpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  pos_row;
  logic [COL_W-1:0]  pos_col;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  step_count;

  modport source (output valid, pos_row, pos_col, status, step_count,
                  input ready);
  modport sink (input valid, pos_row, pos_col, status, step_count,
                output ready);
endinterface

/* design/ggpw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module ggpw_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/grid_greedy_path_walker_unit.sv */
// Grid greedy path walker: occupancy grid, visited map and step sequencer.
// Depends on ggpw_pkg, ggpw_ifs (channels) and ggpw_ram (grid and visited stores).
//
// The block keeps a grid of 2-bit cells and walks greedily toward a destination,
// one move per step command, picking the free unvisited 8-neighbour closest in
// Manhattan distance (later neighbours win ties). It takes one command at a time.
// The step sequencer reads one neighbour per cycle from the grid and visited
// memories through a single read port and compares its distance in one shared
// comparator. The visited map holds an 8-bit walk tag per cell; after reset, and
// on every 255th begin, a clearing pass sweeps all MAX_ROWS*MAX_COLS entries
// (4096 at the default size), during which no command is taken.

module grid_greedy_path_walker_unit import ggpw_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ggpw_in_if.sink     in_i,
  ggpw_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int LIM_ROWS = (MAX_ROWS < FIELD_SPAN) ? MAX_ROWS : FIELD_SPAN;
  localparam int LIM_COLS = (MAX_COLS < FIELD_SPAN) ? MAX_COLS : FIELD_SPAN;

  function automatic logic [AW-1:0] cell_idx(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  function automatic logic in_bounds(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c,
                                     logic [CFG_W-1:0] nr, logic [CFG_W-1:0] nc);
    return (r < nr) && (c < nc);
  endfunction

  // Control state
  state_e               state_q, state_d;
  logic                 clr_ret_q, clr_ret_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic                 act_q, act_d;
  logic [ROW_W-1:0]     wlk_r_q, wlk_r_d, goal_r_q, goal_r_d;
  logic [COL_W-1:0]     wlk_c_q, wlk_c_d, goal_c_q, goal_c_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [3:0]           k_q, k_d;
  logic                 p_vld_q, p_vld_d;
  logic                 found_q, found_d;
  logic                 out_vld_q, out_vld_d;
  logic [CFG_W-1:0]     rows_q, cols_q;
  status_e              stat_q, stat_d;

  // Payload
  logic [ROW_W-1:0]     f_r_q, f_r_d, f_gr_q, f_gr_d, p_r_q, p_r_d, best_r_q, best_r_d;
  logic [COL_W-1:0]     f_c_q, f_c_d, f_gc_q, f_gc_d, p_c_q, p_c_d, best_c_q, best_c_d;
  logic [KIND_W-1:0]    f_kind_q, f_kind_d;
  logic [CFG_W-1:0]     best_h_q, best_h_d;
  logic [ROW_W-1:0]     out_r_q, out_r_d;
  logic [COL_W-1:0]     out_c_q, out_c_d;
  logic [STAT_W-1:0]    out_s_q, out_s_d;
  logic [CNT_W-1:0]     out_n_q, out_n_d;

  // Memory ports
  logic                 cell_we, vis_we;
  logic [AW-1:0]        cell_waddr, vis_waddr, raddr;
  logic [EPOCH_W-1:0]   vis_wdata, vis_rd;
  logic [KIND_W-1:0]    cell_rd;

  // Misc combinational
  logic [CFG_W-1:0]     eff_rows, eff_cols, nb_r, nb_c, h;
  logic                 nb_ok, cand_ok, in_ready, cfg_wr;

  assign eff_rows = (rows_q > CFG_W'(LIM_ROWS)) ? CFG_W'(LIM_ROWS) : rows_q;
  assign eff_cols = (cols_q > CFG_W'(LIM_COLS)) ? CFG_W'(LIM_COLS) : cols_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (cfg_reg_e'(paddr[2]) == REG_COLS) ? {25'd0, cols_q} : {25'd0, rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(ROWS_RESET);
      cols_q <= CFG_W'(COLS_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[2]))
        REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
        REG_COLS: cols_q <= pwdata[CFG_W-1:0];
        default:  rows_q <= rows_q;
      endcase
    end
  end

  ggpw_ram #(.WIDTH(KIND_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (f_kind_q),
    .raddr_i (raddr),
    .rdata_o (cell_rd)
  );

  ggpw_ram #(.WIDTH(EPOCH_W), .DEPTH(DEPTH)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (raddr),
    .rdata_o (vis_rd)
  );

  // Neighbour under address generation, and the one whose data has returned.
  assign nb_r    = apply_off(wlk_r_q, nb_dr(k_q[2:0]));
  assign nb_c    = apply_off(wlk_c_q, nb_dc(k_q[2:0]));
  assign nb_ok   = in_bounds(nb_r, nb_c, eff_rows, eff_cols);
  assign h       = CFG_W'(abs_diff(p_r_q, goal_r_q)) + CFG_W'(abs_diff(p_c_q, goal_c_q));
  // A cell counts as visited only if it carries the current walk tag.
  assign cand_ok = p_vld_q && (cell_rd == CELL_FREE) && (vis_rd != epoch_q);

  assign in_i.ready = in_ready;

  always_comb begin
    state_d   = state_q;
    clr_ret_d = clr_ret_q;
    clr_d     = clr_q;
    epoch_d   = epoch_q;
    act_d     = act_q;
    wlk_r_d   = wlk_r_q;
    wlk_c_d   = wlk_c_q;
    goal_r_d  = goal_r_q;
    goal_c_d  = goal_c_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    p_vld_d   = p_vld_q;
    found_d   = found_q;
    stat_d    = stat_q;
    f_r_d     = f_r_q;
    f_c_d     = f_c_q;
    f_gr_d    = f_gr_q;
    f_gc_d    = f_gc_q;
    f_kind_d  = f_kind_q;
    p_r_d     = p_r_q;
    p_c_d     = p_c_q;
    best_r_d  = best_r_q;
    best_c_d  = best_c_q;
    best_h_d  = best_h_q;
    out_r_d   = out_r_q;
    out_c_d   = out_c_q;
    out_s_d   = out_s_q;
    out_n_d   = out_n_q;
    out_vld_d = out_vld_q && !out_o.ready;
    in_ready  = 1'b0;
    cell_we   = 1'b0;
    cell_waddr = cell_idx({1'b0, f_r_q}, {1'b0, f_c_q});
    vis_we    = 1'b0;
    vis_waddr = clr_q;
    vis_wdata = '0;
    raddr     = '0;

    unique case (state_q)
      S_CLEAR: begin
        vis_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d   = clr_ret_q ? S_BMARK : S_IDLE;
          clr_ret_d = 1'b0;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          f_r_d    = in_i.row;
          f_c_d    = in_i.col;
          f_gr_d   = in_i.dest_row;
          f_gc_d   = in_i.dest_col;
          f_kind_d = in_i.cell_kind;
          k_d      = '0;
          found_d  = 1'b0;
          p_vld_d  = 1'b0;
          priority if (in_i.op == OP_WRITE) begin
            state_d = S_WRITE;
          end else if (in_i.op == OP_BEGIN) begin
            state_d = S_BRD_S;
          end else if (in_i.op == OP_STEP && act_q) begin
            state_d = S_STEP;
          end else begin
            stat_d  = STAT_IDLE;
            state_d = S_FIN;
          end
        end
      end

      S_WRITE: begin
        if (in_bounds({1'b0, f_r_q}, {1'b0, f_c_q}, eff_rows, eff_cols)) begin
          cell_we = 1'b1;
          stat_d  = STAT_OK;
        end else begin
          stat_d  = STAT_IDLE;
        end
        state_d = S_FIN;
      end

      S_BRD_S: begin
        raddr = cell_idx({1'b0, f_r_q}, {1'b0, f_c_q});
        if (in_bounds({1'b0, f_r_q}, {1'b0, f_c_q}, eff_rows, eff_cols) &&
            in_bounds({1'b0, f_gr_q}, {1'b0, f_gc_q}, eff_rows, eff_cols)) begin
          state_d = S_BRD_D;
        end else begin
          act_d   = 1'b0;
          stat_d  = STAT_IDLE;
          state_d = S_FIN;
        end
      end

      S_BRD_D: begin
        raddr = cell_idx({1'b0, f_gr_q}, {1'b0, f_gc_q});
        if (cell_rd == CELL_OBST) begin
          act_d   = 1'b0;
          stat_d  = STAT_START_BLK;
          state_d = S_FIN;
        end else begin
          state_d = S_BCHK;
        end
      end

      S_BCHK: begin
        if (cell_rd == CELL_OBST) begin
          act_d   = 1'b0;
          stat_d  = STAT_DEST_BLK;
          state_d = S_FIN;
        end else if (epoch_q == '1) begin
          // Tags are exhausted: wipe the visited map and restart at tag one.
          epoch_d   = EPOCH_W'(1);
          clr_d     = '0;
          clr_ret_d = 1'b1;
          state_d   = S_CLEAR;
        end else begin
          epoch_d = epoch_q + EPOCH_W'(1);
          state_d = S_BMARK;
        end
      end

      S_BMARK: begin
        vis_we    = 1'b1;
        vis_waddr = cell_idx({1'b0, f_r_q}, {1'b0, f_c_q});
        vis_wdata = epoch_q;
        wlk_r_d   = f_r_q;
        wlk_c_d   = f_c_q;
        goal_r_d  = f_gr_q;
        goal_c_d  = f_gc_q;
        cnt_d     = '0;
        if (f_r_q == f_gr_q && f_c_q == f_gc_q) begin
          act_d  = 1'b0;
          stat_d = STAT_ARRIVED;
        end else begin
          act_d  = 1'b1;
          stat_d = STAT_OK;
        end
        state_d = S_FIN;
      end

      S_STEP: begin
        // Issue neighbour k while judging neighbour k-1 from the read data.
        if (k_q != 4'(NB_COUNT)) begin
          raddr   = cell_idx(nb_r, nb_c);
          p_vld_d = nb_ok;
          p_r_d   = nb_r[ROW_W-1:0];
          p_c_d   = nb_c[COL_W-1:0];
          k_d     = k_q + 4'd1;
        end else begin
          p_vld_d = 1'b0;
          state_d = S_MOVE;
        end
        if (cand_ok && (!found_q || h <= best_h_q)) begin
          found_d  = 1'b1;
          best_h_d = h;
          best_r_d = p_r_q;
          best_c_d = p_c_q;
        end
      end

      S_MOVE: begin
        if (!found_q) begin
          act_d  = 1'b0;
          stat_d = STAT_STUCK;
        end else begin
          vis_we    = 1'b1;
          vis_waddr = cell_idx({1'b0, best_r_q}, {1'b0, best_c_q});
          vis_wdata = epoch_q;
          wlk_r_d   = best_r_q;
          wlk_c_d   = best_c_q;
          if (cnt_q != COUNT_MAX) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (best_r_q == goal_r_q && best_c_q == goal_c_q) begin
            act_d  = 1'b0;
            stat_d = STAT_ARRIVED;
          end else begin
            stat_d = STAT_OK;
          end
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_r_d   = wlk_r_q;
          out_c_d   = wlk_c_q;
          out_s_d   = stat_q;
          out_n_d   = cnt_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_ret_q <= 1'b0;
      clr_q     <= '0;
      epoch_q   <= EPOCH_W'(1);
      act_q     <= 1'b0;
      wlk_r_q   <= '0;
      wlk_c_q   <= '0;
      goal_r_q  <= '0;
      goal_c_q  <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
      p_vld_q   <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      stat_q    <= STAT_OK;
    end else begin
      state_q   <= state_d;
      clr_ret_q <= clr_ret_d;
      clr_q     <= clr_d;
      epoch_q   <= epoch_d;
      act_q     <= act_d;
      wlk_r_q   <= wlk_r_d;
      wlk_c_q   <= wlk_c_d;
      goal_r_q  <= goal_r_d;
      goal_c_q  <= goal_c_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      p_vld_q   <= p_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      stat_q    <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_r_q    <= f_r_d;
    f_c_q    <= f_c_d;
    f_gr_q   <= f_gr_d;
    f_gc_q   <= f_gc_d;
    f_kind_q <= f_kind_d;
    p_r_q    <= p_r_d;
    p_c_q    <= p_c_d;
    best_r_q <= best_r_d;
    best_c_q <= best_c_d;
    best_h_q <= best_h_d;
    out_r_q  <= out_r_d;
    out_c_q  <= out_c_d;
    out_s_q  <= out_s_d;
    out_n_q  <= out_n_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.pos_row    = out_r_q;
  assign out_o.pos_col    = out_c_q;
  assign out_o.status     = out_s_q;
  assign out_o.step_count = out_n_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready)
    else $error("command taken during the visited-map clearing pass");

  a_active_not_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> !(wlk_r_q == goal_r_q && wlk_c_q == goal_c_q))
    else $error("walk still active while standing on the destination");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_FIN))
    else $error("result presented outside the finishing state");

  a_nb_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 4'(NB_COUNT))
    else $error("neighbour index past the last neighbour");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("walk tag equals the cleared value");

endmodule

/* test/grid_greedy_path_walker_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grid_greedy_path_walker_unit: queues grid, begin
// and step commands, predicts every walker result and checks each result transfer.
// Depends on ggpw_pkg, the ggpw channel interfaces and the unit itself.

module grid_greedy_path_walker_unit_tb import ggpw_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int GRID_CELLS  = FIELD_SPAN * FIELD_SPAN;

  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [KIND_W-1:0] CELL_UNKNOWN = 2'd2;
  localparam logic [KIND_W-1:0] CELL_SPARE   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  dest_row;
    logic [COL_W-1:0]  dest_col;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  pos_row;
    logic [COL_W-1:0]  pos_col;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  steps;
  } walk_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ggpw_in_if  cmd_ch ();
  ggpw_out_if res_ch ();

  grid_greedy_path_walker_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_ch.sink),
    .out_o   (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walker model state and its copy of the bound registers.
  logic [KIND_W-1:0] grid_m    [GRID_CELLS];
  bit                visited_m [GRID_CELLS];
  bit                filled_m  [GRID_CELLS];
  logic [ROW_W-1:0]  at_row, goal_row;
  logic [COL_W-1:0]  at_col, goal_col;
  bit                walking;
  logic [CNT_W-1:0]  moves;
  logic [CFG_W-1:0]  rows_reg, cols_reg;

  cmd_t      cmd_backlog [$];
  walk_res_t walk_expect_q [$];
  cmd_t      next_cmd, taken_cmd;
  walk_res_t got_res, want_res;
  int        cmds_queued, cmds_taken, mismatches;
  int        cmd_hold, cmd_calm, res_hold, res_calm, quiet_cycles;

  function automatic int span(logic [CFG_W-1:0] v);
    return (v > FIELD_SPAN) ? FIELD_SPAN : int'(v);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && c >= 0 && r < span(rows_reg) && c < span(cols_reg);
  endfunction

  function automatic int cell_at(int r, int c);
    return r * FIELD_SPAN + c;
  endfunction

  function automatic int distance(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic walk_res_t walker_view(status_e st);
    walk_res_t res;
    res.pos_row = at_row;
    res.pos_col = at_col;
    res.status  = st;
    res.steps   = moves;
    return res;
  endfunction

  function automatic walk_res_t advance_walker(cmd_t cmd);
    int k, dr, dc, nr, nc, h, best;
    bit found;
    logic [ROW_W-1:0] best_r;
    logic [COL_W-1:0] best_c;
    found = 1'b0;
    best = 0;
    best_r = '0;
    best_c = '0;
    case (cmd.op)
      OP_WRITE: begin
        if (!on_grid(cmd.row, cmd.col)) return walker_view(STAT_IDLE);
        grid_m[cell_at(cmd.row, cmd.col)] = cmd.kind;
        return walker_view(STAT_OK);
      end
      OP_BEGIN: begin
        walking = 1'b0;
        if (!on_grid(cmd.row, cmd.col) || !on_grid(cmd.dest_row, cmd.dest_col))
          return walker_view(STAT_IDLE);
        if (grid_m[cell_at(cmd.row, cmd.col)] == CELL_OBST) return walker_view(STAT_START_BLK);
        if (grid_m[cell_at(cmd.dest_row, cmd.dest_col)] == CELL_OBST)
          return walker_view(STAT_DEST_BLK);
        foreach (visited_m[i]) visited_m[i] = 1'b0;
        at_row = cmd.row;
        at_col = cmd.col;
        goal_row = cmd.dest_row;
        goal_col = cmd.dest_col;
        visited_m[cell_at(at_row, at_col)] = 1'b1;
        moves = '0;
        if (at_row == goal_row && at_col == goal_col) return walker_view(STAT_ARRIVED);
        walking = 1'b1;
        return walker_view(STAT_OK);
      end
      OP_STEP: begin
        if (!walking) return walker_view(STAT_IDLE);
        // Order: up, up-left, up-right, down, down-left, down-right, left, right.
        for (k = 0; k < NB_COUNT; k++) begin
          dr = (k < 3) ? -1 : ((k < 6) ? 1 : 0);
          dc = (k == 1 || k == 4 || k == 6) ? -1 : ((k == 2 || k == 5 || k == 7) ? 1 : 0);
          nr = int'(at_row) + dr;
          nc = int'(at_col) + dc;
          if (on_grid(nr, nc) && grid_m[cell_at(nr, nc)] == CELL_FREE
              && !visited_m[cell_at(nr, nc)]) begin
            h = distance(nr, goal_row) + distance(nc, goal_col);
            // A later neighbour at equal distance replaces the earlier one.
            if (!found || h <= best) begin
              found = 1'b1;
              best = h;
              best_r = nr[ROW_W-1:0];
              best_c = nc[COL_W-1:0];
            end
          end
        end
        if (!found) begin
          walking = 1'b0;
          return walker_view(STAT_STUCK);
        end
        at_row = best_r;
        at_col = best_c;
        visited_m[cell_at(at_row, at_col)] = 1'b1;
        if (moves != COUNT_MAX) moves = moves + 1'b1;
        if (at_row == goal_row && at_col == goal_col) begin
          walking = 1'b0;
          return walker_view(STAT_ARRIVED);
        end
        return walker_view(STAT_OK);
      end
      default: return walker_view(STAT_IDLE);
    endcase
  endfunction

  // Mostly back-to-back, with short gaps, a few long ones and calm stretches.
  function automatic int pick_pause(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CELL_FREE;
    if (roll < 88) return CELL_OBST;
    if (roll < 94) return CELL_UNKNOWN;
    return CELL_SPARE;
  endfunction

  task automatic queue_cmd(int op, int r, int c, int kind, int gr, int gc);
    cmd_t cmd;
    cmd.op       = op[OP_W-1:0];
    cmd.row      = r[ROW_W-1:0];
    cmd.col      = c[COL_W-1:0];
    cmd.kind     = kind[KIND_W-1:0];
    cmd.dest_row = gr[ROW_W-1:0];
    cmd.dest_col = gc[COL_W-1:0];
    if (op == OP_WRITE && on_grid(r, c)) filled_m[cell_at(r, c)] = 1'b1;
    cmd_backlog.push_back(cmd);
    cmds_queued++;
  endtask

  task automatic wait_drain();
    while (cmds_taken != cmds_queued || walk_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROWS) rows_reg = value;
    else cols_reg = value;
  endtask

  task automatic set_bounds(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    wait_drain();
    program_reg(REG_ROWS, r);
    program_reg(REG_COLS, c);
  endtask

  // Every cell inside the bounds is written before any walk can read it.
  task automatic fill_grid();
    int r, c;
    for (r = 0; r < span(rows_reg); r++)
      for (c = 0; c < span(cols_reg); c++)
        if (!filled_m[cell_at(r, c)])
          queue_cmd(OP_WRITE, r, c, rand_kind(), $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic queue_walk();
    int nr, nc, steps;
    nr = span(rows_reg);
    nc = span(cols_reg);
    queue_cmd(OP_BEGIN, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
              $urandom_range(0, 3), $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
    steps = $urandom_range(1, nr + nc + 4);
    repeat (steps) begin
      if ($urandom_range(0, 99) < 8)
        queue_cmd(OP_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), rand_kind(),
                  $urandom_range(0, 63), $urandom_range(0, 63));
      queue_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3),
                $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  task automatic queue_mix(int count);
    int stop_at;
    stop_at = cmds_queued + count;
    while (cmds_queued < stop_at) begin
      if (span(rows_reg) == 0 || span(cols_reg) == 0 || $urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(1, 3))
          queue_cmd($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        queue_walk();
      end
      // Now and then the sender holds off until every result is back.
      if ($urandom_range(0, 99) < 4) wait_drain();
    end
  endtask

  // Command driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (cmd_hold > 0) begin
        cmd_hold--;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        cmd_ch.op        <= next_cmd.op;
        cmd_ch.row       <= next_cmd.row;
        cmd_ch.col       <= next_cmd.col;
        cmd_ch.cell_kind <= next_cmd.kind;
        cmd_ch.dest_row  <= next_cmd.dest_row;
        cmd_ch.dest_col  <= next_cmd.dest_col;
        cmd_ch.valid     <= 1'b1;
        cmd_hold = pick_pause(cmd_calm);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (res_hold > 0) begin
      res_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      res_hold = pick_pause(res_calm);
    end
  end

  // Monitor: checks result transfers, then predicts accepted commands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got_res.pos_row = res_ch.pos_row;
        got_res.pos_col = res_ch.pos_col;
        got_res.status  = res_ch.status;
        got_res.steps   = res_ch.step_count;
        if (walk_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: row %0d col %0d status %0d steps %0d",
                     got_res.pos_row, got_res.pos_col, got_res.status, got_res.steps);
          mismatches++;
        end else begin
          want_res = walk_expect_q.pop_front();
          if (got_res.pos_row !== want_res.pos_row || got_res.pos_col !== want_res.pos_col ||
              got_res.status !== want_res.status || got_res.steps !== want_res.steps) begin
            if (mismatches < 10)
              $display("result mismatch: expected row %0d col %0d status %0d steps %0d, %s",
                       want_res.pos_row, want_res.pos_col, want_res.status, want_res.steps,
                       $sformatf("got row %0d col %0d status %0d steps %0d", got_res.pos_row,
                                 got_res.pos_col, got_res.status, got_res.steps));
            mismatches++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken_cmd.op       = cmd_ch.op;
        taken_cmd.row      = cmd_ch.row;
        taken_cmd.col      = cmd_ch.col;
        taken_cmd.kind     = cmd_ch.cell_kind;
        taken_cmd.dest_row = cmd_ch.dest_row;
        taken_cmd.dest_col = cmd_ch.dest_col;
        walk_expect_q.push_back(advance_walker(taken_cmd));
        cmds_taken++;
      end
    end
  end

  // Watchdog: the clearing pass after reset is the longest legal quiet spell.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("grid_greedy_path_walker_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = '0;
    cmd_ch.row       = '0;
    cmd_ch.col       = '0;
    cmd_ch.cell_kind = '0;
    cmd_ch.dest_row  = '0;
    cmd_ch.dest_col  = '0;
    res_ch.ready     = 1'b0;
    at_row = '0;
    at_col = '0;
    goal_row = '0;
    goal_col = '0;
    walking = 1'b0;
    moves = '0;
    rows_reg = CFG_W'(ROWS_RESET);
    cols_reg = CFG_W'(COLS_RESET);
    cmds_queued = 0;
    cmds_taken = 0;
    mismatches = 0;
    cmd_hold = 0;
    cmd_calm = 0;
    res_hold = 0;
    res_calm = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset bounds: nothing here reads the grid.
    queue_cmd(OP_STEP, 0, 0, 0, 0, 0);
    queue_cmd(OP_WRITE, 63, 63, CELL_SPARE, 63, 63);
    queue_cmd(OP_BEGIN, 60, 0, CELL_FREE, 0, 0);
    queue_cmd(OP_UNUSED, 63, 63, CELL_SPARE, 63, 63);

    set_bounds(8, 8);
    fill_grid();
    queue_cmd(OP_WRITE, 0, 0, CELL_FREE, 0, 0);
    queue_cmd(OP_WRITE, 7, 7, CELL_FREE, 0, 0);
    queue_cmd(OP_WRITE, 3, 3, CELL_FREE, 0, 0);
    queue_cmd(OP_WRITE, 1, 1, CELL_FREE, 0, 0);
    queue_cmd(OP_WRITE, 2, 2, CELL_OBST, 0, 0);
    queue_cmd(OP_WRITE, 5, 5, CELL_OBST, 0, 0);
    queue_cmd(OP_BEGIN, 2, 2, CELL_FREE, 0, 0);
    queue_cmd(OP_BEGIN, 0, 0, CELL_FREE, 5, 5);
    queue_cmd(OP_BEGIN, 3, 3, CELL_FREE, 3, 3);
    // Wall in the far corner so the walk from there gets stuck at once.
    queue_cmd(OP_WRITE, 6, 7, CELL_OBST, 0, 0);
    queue_cmd(OP_WRITE, 6, 6, CELL_OBST, 0, 0);
    queue_cmd(OP_WRITE, 7, 6, CELL_OBST, 0, 0);
    queue_cmd(OP_BEGIN, 7, 7, CELL_FREE, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0, 0, 0);
    queue_cmd(OP_BEGIN, 0, 0, CELL_FREE, 1, 1);
    queue_cmd(OP_STEP, 63, 63, CELL_SPARE, 63, 63);
    queue_cmd(OP_STEP, 0, 0, 0, 0, 0);
    queue_cmd(OP_WRITE, 63, 63, CELL_SPARE, 63, 63);
    queue_cmd(OP_UNUSED, 0, 0, 0, 0, 0);
    queue_cmd(OP_BEGIN, 0, 0, CELL_FREE, 8, 0);
    queue_mix(70);

    set_bounds(127, 1);
    fill_grid();
    queue_mix(35);

    set_bounds(1, 64);
    fill_grid();
    queue_mix(35);

    set_bounds(0, 0);
    queue_mix(20);

    set_bounds(16, 12);
    fill_grid();
    queue_mix(120);

    set_bounds(3, 127);
    fill_grid();
    queue_mix(60);

    wait_drain();
    repeat (20) @(posedge clk_i);
    mismatches += walk_expect_q.size();
    if (mismatches == 0) begin
      $display("grid_greedy_path_walker_unit verification clean");
    end else begin
      $display("grid_greedy_path_walker_unit verification failed");
    end
    $finish;
  end

endmodule
